### hdl/clm_pkg.sv
// shared types and constants for the circular list manager
package clm_pkg;

    localparam int OP_W    = 4;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 3;

    localparam logic [OP_W-1:0] OP_INS_HEAD = 4'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 4'd1;
    localparam logic [OP_W-1:0] OP_INS_POS  = 4'd2;
    localparam logic [OP_W-1:0] OP_DEL_HEAD = 4'd3;
    localparam logic [OP_W-1:0] OP_DEL_TAIL = 4'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS  = 4'd5;
    localparam logic [OP_W-1:0] OP_SEARCH   = 4'd6;
    localparam logic [OP_W-1:0] OP_READ     = 4'd7;
    localparam logic [OP_W-1:0] OP_COUNT    = 4'd8;
    localparam logic [OP_W-1:0] OP_DUMP     = 4'd9;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD_POS  = 3'd2;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_WALK,
        S_COMMIT,
        S_OUT
    } clm_state_t;

endpackage

### hdl/clm_alloc.sv
// lowest free node finder, one node checked per cycle
module clm_alloc
    import clm_pkg::*;
#(
    parameter int CAPACITY = 32,
    parameter int IDX_W    = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [CAPACITY-1:0] occupied,
    output logic                done,
    output logic                found,
    output logic [IDX_W-1:0]    index
);

    logic [IDX_W:0] scan_reg, scan_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic           found_reg, found_next;

    always_comb begin
        scan_next  = scan_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        if (start) begin
            scan_next  = '0;
            busy_next  = 1'b1;
            found_next = 1'b0;
        end else if (busy_reg) begin
            if (scan_reg == (IDX_W+1)'(CAPACITY)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (!occupied[scan_reg[IDX_W-1:0]]) begin
                busy_next  = 1'b0;
                done_next  = 1'b1;
                found_next = 1'b1;
            end else begin
                scan_next = scan_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg  <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            scan_reg  <= scan_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            found_reg <= found_next;
        end
    end

    assign done  = done_reg;
    assign found = found_reg;
    assign index = scan_reg[IDX_W-1:0];

endmodule

### hdl/circular_list_manager.sv
// circular list manager top level: node store, walker and sequencer
// without stalls, time per item is set by the free scan and the node walk
// throughput: one item at a time, s_tready low until the last result is taken
// dump emits one result per node as the walk advances
// reset: synchronous active-low, list empty; node store needs no clearing
module circular_list_manager
    import clm_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // op[3:0], position[10:4], value[42:11]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // status[2:0], value_out[34:3], position_out[41:35]
    output logic        m_tlast
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [VAL_W-1:0] val_mem [CAPACITY];
    logic [IDX_W-1:0] link_mem [CAPACITY];

    clm_state_t state_reg, state_next;
    logic [CAPACITY-1:0] occ_reg, occ_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [OP_W-1:0]  op_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [VAL_W-1:0] val_reg;
    logic [IDX_W-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic [POS_W-1:0] k_reg, k_next;
    logic [ST_W-1:0]  st_reg, st_next;
    logic [VAL_W-1:0] vout_reg, vout_next;
    logic [POS_W-1:0] pout_reg, pout_next;
    logic             last_reg, last_next;
    logic             mv_reg, mv_next;
    logic [IDX_W-1:0] new_reg, new_next;

    logic [IDX_W-1:0] lnk_rd_reg;
    logic [VAL_W-1:0] val_rd_reg;
    logic [IDX_W-1:0] head_reg;

    logic             wr_val_en, wr_lnk_en, wr_lnk2_en;
    logic [IDX_W-1:0] wr_val_a, wr_lnk_a, wr_lnk2_a, wr_lnk_d, wr_lnk2_d;

    logic             alloc_start, alloc_done, alloc_found;
    logic [IDX_W-1:0] alloc_idx;

    logic [OP_W-1:0]  in_op;
    logic [POS_W-1:0] in_pos;
    logic [VAL_W-1:0] in_val;
    logic [POS_W-1:0] cnt_w;
    logic             is_ins, is_del;

    assign in_op  = s_tdata[3:0];
    assign in_pos = s_tdata[10:4];
    assign in_val = s_tdata[42:11];
    assign cnt_w  = POS_W'(cnt_reg);
    assign is_ins = (op_reg == OP_INS_HEAD) || (op_reg == OP_INS_TAIL)
                    || (op_reg == OP_INS_POS);
    assign is_del = (op_reg == OP_DEL_HEAD) || (op_reg == OP_DEL_TAIL)
                    || (op_reg == OP_DEL_POS);

    clm_alloc #(.CAPACITY(CAPACITY), .IDX_W(IDX_W)) u_alloc (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (alloc_start),
        .occupied (occ_reg),
        .done     (alloc_done),
        .found    (alloc_found),
        .index    (alloc_idx)
    );

    always_ff @(posedge aclk) begin
        if (wr_val_en) val_mem[wr_val_a] <= val_reg;
        if (wr_lnk_en) link_mem[wr_lnk_a] <= wr_lnk_d;
        if (wr_lnk2_en) link_mem[wr_lnk2_a] <= wr_lnk2_d;
    end

    // registered reads of the node under the walker and of the head link
    always_ff @(posedge aclk) begin
        lnk_rd_reg <= link_mem[cur_next];
        val_rd_reg <= val_mem[cur_next];
        head_reg   <= link_mem[tail_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
            tail_reg  <= '0;
            cnt_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            tail_reg  <= tail_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            op_reg  <= in_op;
            val_reg <= in_val;
        end
        pos_reg  <= pos_next;
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        k_reg    <= k_next;
        st_reg   <= st_next;
        vout_reg <= vout_next;
        pout_reg <= pout_next;
        last_reg <= last_next;
        new_reg  <= new_next;
    end

    // walk target: node at position pos_reg; inserts and deletes also track its predecessor
    always_comb begin
        state_next = state_reg;
        occ_next   = occ_reg;
        tail_next  = tail_reg;
        cnt_next   = cnt_reg;
        mv_next    = mv_reg;
        pos_next   = pos_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        k_next     = k_reg;
        st_next    = st_reg;
        vout_next  = vout_reg;
        pout_next  = pout_reg;
        last_next  = last_reg;
        new_next   = new_reg;
        alloc_start = 1'b0;
        wr_val_en  = 1'b0;
        wr_val_a   = new_reg;
        wr_lnk_en  = 1'b0;
        wr_lnk_a   = new_reg;
        wr_lnk_d   = '0;
        wr_lnk2_en = 1'b0;
        wr_lnk2_a  = prev_reg;
        wr_lnk2_d  = new_reg;
        s_tready   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    vout_next = '0;
                    pout_next = '0;
                    last_next = 1'b1;
                    st_next   = ST_OK;
                    k_next    = POS_W'(1);
                    cur_next  = head_reg;
                    prev_next = tail_reg;
                    state_next = S_OUT;
                    case (in_op)
                        OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                            pos_next = (in_op == OP_INS_HEAD) ? POS_W'(1) :
                                       (in_op == OP_INS_TAIL) ? cnt_w + 1'b1 : in_pos;
                            if (in_op == OP_INS_POS &&
                                (in_pos == '0 || in_pos > cnt_w + 1'b1)) begin
                                st_next = ST_BAD_POS;
                            end else begin
                                alloc_start = 1'b1;
                                state_next  = S_ALLOC;
                            end
                        end
                        OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_POS: begin
                            pos_next = (in_op == OP_DEL_HEAD) ? POS_W'(1) :
                                       (in_op == OP_DEL_TAIL) ? cnt_w : in_pos;
                            if (cnt_reg == '0)
                                st_next = ST_EMPTY;
                            else if (in_op == OP_DEL_POS &&
                                     (in_pos == '0 || in_pos > cnt_w))
                                st_next = ST_BAD_POS;
                            else
                                state_next = S_WALK;
                        end
                        OP_SEARCH, OP_DUMP: begin
                            pos_next = cnt_w;
                            if (cnt_reg == '0) begin
                                st_next = ST_EMPTY;
                            end else begin
                                state_next = S_WALK;
                            end
                        end
                        OP_READ: begin
                            pos_next = in_pos;
                            if (cnt_reg == '0)
                                st_next = ST_EMPTY;
                            else if (in_pos == '0 || in_pos > cnt_w)
                                st_next = ST_BAD_POS;
                            else
                                state_next = S_WALK;
                        end
                        OP_COUNT: pout_next = cnt_w;
                        default: state_next = S_IDLE;
                    endcase
                    mv_next = (state_next == S_OUT);
                end
            end
            S_ALLOC: begin
                if (alloc_done) begin
                    new_next = alloc_idx;
                    if (!alloc_found) begin
                        st_next = ST_FULL;
                        mv_next = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                // cur is node at k; for inserts and deletes prev is its predecessor
                if (is_ins || is_del) begin
                    if (is_ins && (cnt_reg == '0 || k_reg >= pos_reg)) begin
                        state_next = S_COMMIT;
                    end else if (is_del && k_reg >= pos_reg) begin
                        state_next = S_COMMIT;
                    end else begin
                        prev_next = cur_reg;
                        cur_next  = lnk_rd_reg;
                        k_next    = k_reg + 1'b1;
                    end
                end else if (op_reg == OP_SEARCH) begin
                    if (val_rd_reg == val_reg) begin
                        pout_next = k_reg;
                        mv_next = 1'b1;
                        state_next = S_OUT;
                    end else if (k_reg >= pos_reg) begin
                        st_next = ST_NOTFOUND;
                        mv_next = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        cur_next = lnk_rd_reg;
                        k_next   = k_reg + 1'b1;
                    end
                end else if (op_reg == OP_READ) begin
                    if (k_reg >= pos_reg) begin
                        vout_next = val_rd_reg;
                        mv_next = 1'b1;
                        state_next = S_OUT;
                    end else begin
                        cur_next = lnk_rd_reg;
                        k_next   = k_reg + 1'b1;
                    end
                end else begin
                    vout_next = val_rd_reg;
                    last_next = (k_reg >= pos_reg);
                    mv_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_COMMIT: begin
                if (is_ins) begin
                    wr_val_en = 1'b1;
                    occ_next  = occ_reg | (CAPACITY'(1) << new_reg);
                    cnt_next  = cnt_reg + 1'b1;
                    wr_lnk_en = 1'b1;
                    if (cnt_reg == '0) begin
                        wr_lnk_d  = new_reg;
                        tail_next = new_reg;
                    end else begin
                        wr_lnk_d   = cur_reg;
                        wr_lnk2_en = 1'b1;
                        if (pos_reg == cnt_w + 1'b1) tail_next = new_reg;
                    end
                end else begin
                    occ_next = occ_reg & ~(CAPACITY'(1) << cur_reg);
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        tail_next = '0;
                    end else begin
                        wr_lnk2_en = 1'b1;
                        wr_lnk2_d  = lnk_rd_reg;
                        if (cur_reg == tail_reg) tail_next = prev_reg;
                    end
                end
                mv_next = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    mv_next = 1'b0;
                    if (last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        cur_next = lnk_rd_reg;
                        k_next   = k_reg + 1'b1;
                        state_next = S_WALK;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_tvalid = mv_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {6'd0, pout_reg, vout_reg, st_reg};

    property p_out_state;
        @(posedge aclk) disable iff (!aresetn) m_tvalid |-> state_reg == S_OUT;
    endproperty
    a_out_state: assert property (p_out_state) else $error("result outside output state");

    property p_cnt_bound;
        @(posedge aclk) disable iff (!aresetn) cnt_reg <= CNT_W'(CAPACITY);
    endproperty
    a_cnt_bound: assert property (p_cnt_bound) else $error("node count overflow");

    property p_occ_count;
        @(posedge aclk) disable iff (!aresetn)
            state_reg == S_IDLE |-> $countones(occ_reg) == int'(cnt_reg);
    endproperty
    a_occ_count: assert property (p_occ_count) else $error("occupancy and count disagree");

endmodule
